// ===== src/sxl_pkg.sv =====
// Package with the request and response types, codes and limits of the shared-exclusive latch.
`default_nettype none
package sxl_pkg;

	// Largest shared-holder count that is asked for, and the number of known requesters.
	localparam int READER_MAX      = 255;
	localparam int REQUESTER_COUNT = 256;

	// The counter is eight bits wide, so the usable limit never exceeds 255.
	localparam int READER_LIMIT = (READER_MAX > 255) ? 255 : READER_MAX;

	// Operation codes of a request.
	typedef enum logic [2:0] {
		OP_ACQ_SHARED = 3'd0,
		OP_ACQ_SX     = 3'd1,
		OP_ACQ_EXCL   = 3'd2,
		OP_REL_SHARED = 3'd3,
		OP_REL_SX     = 3'd4,
		OP_REL_EXCL   = 3'd5,
		OP_UPGRADE    = 3'd6,
		OP_DOWNGRADE  = 3'd7
	} sxl_op_t;

	// Answer codes.
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_WAIT   = 2'd1,
		ST_REFUSE = 2'd2
	} sxl_status_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] requester_id;
	} sxl_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       wake_waiters;
		logic [7:0] reader_total;
	} sxl_rsp_t;

endpackage
`default_nettype wire

// ===== src/shared_sx_exclusive_latch.sv =====
// Shared / shared-exclusive / exclusive latch answering one request per cycle while rsp_ready does not hold it back.
// A request passes through the input register and then the result register before response valid rises.
// Throughput: one request per cycle while rsp_ready holds; the lock state update is decided combinationally.
// A new request enters whenever the input register is empty or its item moves on that cycle.
// Reset (arst_n low, asynchronous): no readers, no writer, no sx holder, no pending upgrade.
`default_nettype none
module shared_sx_exclusive_latch #(
	parameter int READER_MAX      = sxl_pkg::READER_MAX,
	parameter int REQUESTER_COUNT = sxl_pkg::REQUESTER_COUNT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire sxl_pkg::sxl_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output sxl_pkg::sxl_rsp_t      rsp
);
	import sxl_pkg::*;

	// The counter is eight bits wide, so the usable limit never exceeds 255.
	localparam logic [7:0]  LIMIT_C    = 8'((READER_MAX > 255) ? 255 : READER_MAX);
	localparam logic [16:0] REQ_CNT_C  = 17'(REQUESTER_COUNT);

	// Input register.
	logic     valid_s1;
	sxl_req_t req_s1;

	// Result register.
	logic     rsp_valid_q;
	sxl_rsp_t rsp_q;

	// Lock state.
	logic [7:0] reader_count_q;
	logic       writer_held_q;
	logic       sx_held_q;
	logic [7:0] sx_id_q;
	logic       upgrade_pending_q;

	// Next-state and answer of the item in the input register.
	logic [7:0]  reader_count_d;
	logic        writer_held_d;
	logic        sx_held_d;
	logic [7:0]  sx_id_d;
	logic        upgrade_pending_d;
	sxl_status_t status_d;
	logic        wake_d;
	logic        id_ok;
	logic        advance;

	// The input stage moves on whenever the result register is empty or being emptied.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign id_ok = {9'd0, req_s1.requester_id} < REQ_CNT_C;

	// Decide the answer and the new lock state.
	always_comb begin
		reader_count_d    = reader_count_q;
		writer_held_d     = writer_held_q;
		sx_held_d         = sx_held_q;
		sx_id_d           = sx_id_q;
		upgrade_pending_d = upgrade_pending_q;
		status_d          = ST_DONE;
		wake_d            = 1'b0;
		if (!id_ok) begin
			status_d = ST_REFUSE;
		end else begin
			case (req_s1.opcode)
				OP_ACQ_SHARED: begin
					if (writer_held_q || upgrade_pending_q || reader_count_q >= LIMIT_C) begin
						status_d = ST_WAIT;
					end else begin
						reader_count_d = reader_count_q + 8'd1;
					end
				end
				OP_ACQ_SX: begin
					if (writer_held_q || sx_held_q) begin
						status_d = ST_WAIT;
					end else begin
						sx_held_d = 1'b1;
						sx_id_d   = req_s1.requester_id;
					end
				end
				OP_ACQ_EXCL: begin
					if (reader_count_q != 8'd0 || writer_held_q || sx_held_q) begin
						status_d = ST_WAIT;
					end else begin
						writer_held_d = 1'b1;
					end
				end
				OP_REL_SHARED: begin
					if (reader_count_q == 8'd0) begin
						status_d = ST_REFUSE;
					end else begin
						reader_count_d = reader_count_q - 8'd1;
						wake_d         = (reader_count_q == 8'd1);
					end
				end
				OP_REL_SX: begin
					// A pending upgrade belongs to the sx holder, so it goes too.
					sx_held_d         = 1'b0;
					upgrade_pending_d = 1'b0;
					wake_d            = 1'b1;
				end
				OP_REL_EXCL: begin
					writer_held_d = 1'b0;
					wake_d        = 1'b1;
				end
				OP_UPGRADE: begin
					if (!sx_held_q || sx_id_q != req_s1.requester_id) begin
						status_d = ST_REFUSE;
					end else if (reader_count_q != 8'd0) begin
						upgrade_pending_d = 1'b1;
						status_d          = ST_WAIT;
					end else begin
						sx_held_d         = 1'b0;
						writer_held_d     = 1'b1;
						upgrade_pending_d = 1'b0;
						wake_d            = 1'b1;
					end
				end
				default: begin
					// Downgrade from exclusive to shared-exclusive.
					if (!writer_held_q || sx_held_q) begin
						status_d = ST_REFUSE;
					end else begin
						writer_held_d     = 1'b0;
						sx_held_d         = 1'b1;
						sx_id_d           = req_s1.requester_id;
						upgrade_pending_d = 1'b0;
						wake_d            = 1'b1;
					end
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Result valid, loaded on every advance, and lock state, updated once per item leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q       <= 1'b0;
			reader_count_q    <= 8'd0;
			writer_held_q     <= 1'b0;
			sx_held_q         <= 1'b0;
			sx_id_q           <= 8'd0;
			upgrade_pending_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				reader_count_q    <= reader_count_d;
				writer_held_q     <= writer_held_d;
				sx_held_q         <= sx_held_d;
				sx_id_q           <= sx_id_d;
				upgrade_pending_q <= upgrade_pending_d;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.status       <= status_d;
			rsp_q.wake_waiters <= wake_d;
			rsp_q.reader_total <= reader_count_d;
		end
	end

endmodule
`default_nettype wire
